/* src/natpt_pkg.sv */
// Package for the NAT port translation table: request and result types,
// entry layout, verdict and class codes. No dependencies.
`default_nettype none
package natpt_pkg;

  typedef struct packed {
    logic        func;
    logic [1:0]  direction;
    logic        is_tcp;
    logic [31:0] src_ip;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_port;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] new_src_ip;
    logic [15:0] new_src_port;
    logic [31:0] new_dst_ip;
    logic [15:0] new_dst_port;
    logic [8:0]  entries_removed;
  } out_item_t;

  // Verdict codes.
  localparam logic [2:0] V_FWD     = 3'd0;
  localparam logic [2:0] V_UNREACH = 3'd1;
  localparam logic [2:0] V_NONTCP  = 3'd2;
  localparam logic [2:0] V_NORES   = 3'd3;
  localparam logic [2:0] V_TICK    = 3'd4;

  // Direction codes.
  localparam logic [1:0] DIR_OUT = 2'd0;
  localparam logic [1:0] DIR_IN  = 2'd1;

  // Request classes decided by the front end.
  localparam logic [2:0] CLS_TICK    = 3'd0;
  localparam logic [2:0] CLS_UNREACH = 3'd1;
  localparam logic [2:0] CLS_NONTCP  = 3'd2;
  localparam logic [2:0] CLS_IN      = 3'd3;
  localparam logic [2:0] CLS_OUT     = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_EXT_IP  = 2'd0;
  localparam logic [1:0] REG_PORT_BASE = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic [31:0] EXT_IP_RST    = 32'd0;
  localparam logic [15:0] PORT_BASE_RST = 16'd12288;
  localparam logic [15:0] TIMEOUT_RST   = 16'd60;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;

  // Port pool bitmap is stored in words of this many bits.
  localparam int POOL_WORD  = 32;
  localparam int POOL_BIT_W = 5;

  typedef struct packed {
    logic [2:0] cls;
    in_item_t   item;
  } q_item_t;

  typedef struct packed {
    logic    vld;
    q_item_t data;
  } q_side_t;

  typedef struct packed {
    logic [31:0] ext_ip;
    logic [15:0] port_base;
    logic [15:0] idle_timeout;
  } cfg_t;

  typedef struct packed {
    logic [31:0] inside_ip;
    logic [15:0] inside_port;
    logic [31:0] remote_ip;
    logic [15:0] outside_port;
    logic [15:0] idle_age;
  } entry_t;

endpackage
`default_nettype wire

/* src/natpt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module natpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* src/natpt_front.sv */
// Front end: accepts requests, classifies them and holds them in a
// two-deep queue for the back end. Depends on natpt_pkg.
`default_nettype none
module natpt_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_en,
  input  wire natpt_pkg::in_item_t item,
  output logic                    full,
  output natpt_pkg::q_side_t      q,
  input  wire logic               q_pop
);
  natpt_pkg::q_item_t slot_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] cls;

  // Invalid direction is reported before the protocol check.
  always_comb begin
    if (item.func) begin
      cls = natpt_pkg::CLS_TICK;
    end else if (item.direction != natpt_pkg::DIR_OUT &&
                 item.direction != natpt_pkg::DIR_IN) begin
      cls = natpt_pkg::CLS_UNREACH;
    end else if (!item.is_tcp) begin
      cls = natpt_pkg::CLS_NONTCP;
    end else if (item.direction == natpt_pkg::DIR_IN) begin
      cls = natpt_pkg::CLS_IN;
    end else begin
      cls = natpt_pkg::CLS_OUT;
    end
  end

  assign full   = (cnt_r == 2'd2);
  assign q.vld  = (cnt_r != 2'd0);
  assign q.data = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ push_en;
    rptr_nxt = rptr_r ^ q_pop;
    cnt_nxt  = cnt_r + {1'b0, push_en} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      slot_r[wptr_r] <= '{cls: cls, item: item};
    end
  end
endmodule
`default_nettype wire

/* src/natpt_back.sv */
// Back end: walks the translation table, allocates pool ports, ages
// entries on ticks and holds the finished result. Depends on natpt_pkg
// and natpt_ram.
`default_nettype none
module natpt_back #(
  parameter int TABLE_ENTRIES = 256,
  parameter int PORT_POOL     = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire natpt_pkg::q_side_t  q,
  output logic                     q_pop,
  output logic                     clearing,
  input  wire natpt_pkg::cfg_t     cfg,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output natpt_pkg::out_item_t     out_item
);
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int SLOT_W = $clog2(PORT_POOL);
  localparam int PW     = natpt_pkg::POOL_WORD;
  localparam int BW     = natpt_pkg::POOL_BIT_W;
  localparam int PROWS  = (PORT_POOL + PW - 1) / PW;
  localparam int PROW_W = (PROWS > 1) ? $clog2(PROWS) : 1;
  localparam int EW     = $bits(natpt_pkg::entry_t) + SLOT_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PCHK  = 4'd4;
  localparam logic [3:0] S_TRD   = 4'd5;
  localparam logic [3:0] S_TCHK  = 4'd6;
  localparam logic [3:0] S_TFREE = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]               st_r, st_nxt;
  natpt_pkg::in_item_t      cur_r, cur_nxt;
  logic [2:0]               cls_r, cls_nxt;
  logic [CNT_W-1:0]         rd_idx_r, rd_idx_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [PROW_W-1:0]        pw_r, pw_nxt;
  logic [PROW_W-1:0]        clr_r, clr_nxt;
  logic [8:0]               rem_r, rem_nxt;
  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  natpt_pkg::out_item_t     res_r, res_nxt;
  natpt_pkg::out_item_t     out_r, out_nxt;
  logic                     out_vld_r, out_vld_nxt;

  logic                     e_we, e_re;
  logic [IDX_W-1:0]         e_waddr, e_raddr;
  logic [EW-1:0]            e_wdata, e_q;
  logic                     p_we, p_re;
  logic [PROW_W-1:0]        p_waddr, p_raddr;
  logic [PW-1:0]            p_wdata, p_q;

  natpt_pkg::entry_t        ent, ent_w;
  logic [SLOT_W-1:0]        ent_slot;
  logic                     hit;
  logic [15:0]              age_n;
  logic [PW-1:0]            word_eff;
  logic                     bit_found;
  logic [BW-1:0]            bit_idx;
  logic [PROW_W+BW-1:0]     new_slot_ext, old_slot_ext;
  logic [SLOT_W-1:0]        new_slot;
  logic [15:0]              new_port;
  logic [IDX_W-1:0]         rd_addr;

  natpt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_q)
  );

  natpt_ram #(.WIDTH(PW), .DEPTH(PROWS)) u_pool_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(p_q)
  );

  assign {ent, ent_slot} = e_q;
  assign rd_addr = rd_idx_r[IDX_W-1:0];

  always_comb begin
    if (cls_r == natpt_pkg::CLS_IN) begin
      hit = ent.outside_port == cur_r.dst_port && ent.remote_ip == cur_r.src_ip;
    end else begin
      hit = ent.inside_ip == cur_r.src_ip && ent.inside_port == cur_r.src_port &&
            ent.remote_ip == cur_r.dst_ip;
    end
    hit = hit && valid_r[cmp_idx_r];
  end

  assign age_n = (ent.idle_age == natpt_pkg::AGE_MAX) ? ent.idle_age
               : ent.idle_age + 16'd1;

  // Pool bits past the end of the pool read as taken. Lowest free bit wins.
  always_comb begin
    bit_found = 1'b0;
    bit_idx   = '0;
    for (int b = 0; b < PW; b++) begin
      word_eff[b] = p_q[b] || (int'(pw_r) * PW + b >= PORT_POOL);
    end
    for (int b = PW - 1; b >= 0; b--) begin
      if (!word_eff[b]) begin
        bit_found = 1'b1;
        bit_idx   = BW'(b);
      end
    end
  end

  assign new_slot_ext = {pw_r, bit_idx};
  assign new_slot     = new_slot_ext[SLOT_W-1:0];
  assign new_port     = cfg.port_base + 16'(new_slot);
  assign old_slot_ext = (PROW_W + BW)'(slot_r);

  always_comb begin
    st_nxt         = st_r;
    cur_nxt        = cur_r;
    cls_nxt        = cls_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    pw_nxt         = pw_r;
    clr_nxt        = clr_r;
    rem_nxt        = rem_r;
    slot_nxt       = slot_r;
    valid_nxt      = valid_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_vld_nxt    = out_vld_r && !out_pop;
    q_pop          = 1'b0;
    e_we = 1'b0; e_waddr = cmp_idx_r; e_wdata = e_q;
    e_re = 1'b0; e_raddr = rd_addr;
    p_we = 1'b0; p_waddr = pw_r; p_wdata = p_q;
    p_re = 1'b0; p_raddr = pw_r;
    ent_w = ent;

    unique case (st_r)
      S_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_r;
        p_wdata = '0;
        clr_nxt = clr_r + PROW_W'(1);
        if (int'(clr_r) == PROWS - 1) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q.vld) begin
          q_pop          = 1'b1;
          cur_nxt        = q.data.item;
          cls_nxt        = q.data.cls;
          rd_idx_nxt     = '0;
          free_found_nxt = 1'b0;
          rem_nxt        = '0;
          pw_nxt         = '0;
          res_nxt        = '0;
          case (q.data.cls)
            natpt_pkg::CLS_TICK: st_nxt = S_TRD;
            natpt_pkg::CLS_UNREACH: begin
              res_nxt.verdict = natpt_pkg::V_UNREACH;
              st_nxt = S_DONE;
            end
            natpt_pkg::CLS_NONTCP: begin
              res_nxt.verdict = natpt_pkg::V_NONTCP;
              st_nxt = S_DONE;
            end
            default: st_nxt = S_WALK;
          endcase
        end
      end
      S_WALK: begin
        // Reads run one entry ahead of the compare.
        if (int'(rd_idx_r) < TABLE_ENTRIES) begin
          e_re        = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_addr;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end
        if (cmp_vld_r) begin
          if (!valid_r[cmp_idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cmp_idx_r;
          end
          if (hit) begin
            ent_w.idle_age = '0;
            e_we    = 1'b1;
            e_waddr = cmp_idx_r;
            e_wdata = {ent_w, ent_slot};
            res_nxt.verdict = natpt_pkg::V_FWD;
            if (cls_r == natpt_pkg::CLS_IN) begin
              res_nxt.new_src_ip   = cur_r.src_ip;
              res_nxt.new_src_port = cur_r.src_port;
              res_nxt.new_dst_ip   = ent.inside_ip;
              res_nxt.new_dst_port = ent.inside_port;
            end else begin
              res_nxt.new_src_ip   = cfg.ext_ip;
              res_nxt.new_src_port = ent.outside_port;
              res_nxt.new_dst_ip   = cur_r.dst_ip;
              res_nxt.new_dst_port = cur_r.dst_port;
            end
            cmp_vld_nxt = 1'b0;
            st_nxt = S_DONE;
          end
        end else if (int'(rd_idx_r) == TABLE_ENTRIES) begin
          if (cls_r == natpt_pkg::CLS_IN) begin
            res_nxt.verdict = natpt_pkg::V_UNREACH;
            st_nxt = S_DONE;
          end else if (!free_found_r) begin
            res_nxt.verdict = natpt_pkg::V_NORES;
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_PRD;
          end
        end
      end
      S_PRD: begin
        p_re   = 1'b1;
        st_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (bit_found) begin
          p_we    = 1'b1;
          p_wdata = p_q | (PW'(1) << bit_idx);
          ent_w.inside_ip    = cur_r.src_ip;
          ent_w.inside_port  = cur_r.src_port;
          ent_w.remote_ip    = cur_r.dst_ip;
          ent_w.outside_port = new_port;
          ent_w.idle_age     = '0;
          e_we    = 1'b1;
          e_waddr = free_idx_r;
          e_wdata = {ent_w, new_slot};
          valid_nxt[free_idx_r] = 1'b1;
          res_nxt.verdict      = natpt_pkg::V_FWD;
          res_nxt.new_src_ip   = cfg.ext_ip;
          res_nxt.new_src_port = new_port;
          res_nxt.new_dst_ip   = cur_r.dst_ip;
          res_nxt.new_dst_port = cur_r.dst_port;
          st_nxt = S_DONE;
        end else if (int'(pw_r) == PROWS - 1) begin
          res_nxt.verdict = natpt_pkg::V_NORES;
          st_nxt = S_DONE;
        end else begin
          pw_nxt = pw_r + PROW_W'(1);
          st_nxt = S_PRD;
        end
      end
      S_TRD: begin
        if (int'(rd_idx_r) == TABLE_ENTRIES) begin
          res_nxt.verdict         = natpt_pkg::V_TICK;
          res_nxt.entries_removed = rem_r;
          st_nxt = S_DONE;
        end else if (valid_r[rd_addr]) begin
          e_re   = 1'b1;
          st_nxt = S_TCHK;
        end else begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
        end
      end
      S_TCHK: begin
        ent_w.idle_age = age_n;
        e_we    = 1'b1;
        e_waddr = rd_addr;
        e_wdata = {ent_w, ent_slot};
        if (age_n > cfg.idle_timeout) begin
          valid_nxt[rd_addr] = 1'b0;
          rem_nxt  = rem_r + 9'd1;
          slot_nxt = ent_slot;
          p_re     = 1'b1;
          p_raddr  = PROW_W'(((PROW_W + BW)'(ent_slot)) >> BW);
          st_nxt   = S_TFREE;
        end else begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          st_nxt     = S_TRD;
        end
      end
      S_TFREE: begin
        p_we       = 1'b1;
        p_waddr    = old_slot_ext[PROW_W+BW-1:BW];
        p_wdata    = p_q & ~(PW'(1) << old_slot_ext[BW-1:0]);
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
        st_nxt     = S_TRD;
      end
      S_DONE: begin
        if (!out_vld_r || out_pop) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          st_nxt      = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign clearing  = (st_r == S_CLEAR);
  assign out_empty = !out_vld_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLEAR;
      clr_r     <= '0;
      valid_r   <= '0;
      out_vld_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      clr_r     <= clr_nxt;
      valid_r   <= valid_nxt;
      out_vld_r <= out_vld_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    cls_r        <= cls_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    pw_r         <= pw_nxt;
    rem_r        <= rem_nxt;
    slot_r       <= slot_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end
endmodule
`default_nettype wire

/* src/nat_port_translation_table.sv */
// Top level of the NAT port translation table: configuration registers,
// front end queue and back end table engine. Depends on natpt_pkg,
// natpt_front and natpt_back.
`default_nettype none
// The block translates one request at a time, either a TCP header tuple
// whose direction is already known or a one-second aging tick, and returns
// exactly one result per request through a queue-style port. The front end
// classifies requests into a two-deep queue, so requests can be pushed while
// the table engine is busy and while a result waits to be popped. The
// engine owns one table memory read and written once per cycle, and that
// port sets the timing: an inbound or outbound lookup walks the entries in
// order until a hit or the end of the table; an outbound miss with a free
// entry then reads the 32-port words of the pool bitmap in turn until a free
// port is found; a tick reads and ages every live entry and frees the pool
// bit of each removed entry. Dropped requests (invalid direction, non-TCP)
// skip the table. After reset the pool bitmap memory is cleared one word a
// cycle, during which in_full stays high; configuration writes are taken
// at any time and cfg_ready is always high, but registers should only be
// written while the block is idle.
module nat_port_translation_table #(
  parameter int TABLE_ENTRIES = 256,
  parameter int PORT_POOL     = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  output logic                      in_full,
  input  wire natpt_pkg::in_item_t  in_item,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output natpt_pkg::out_item_t      out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  natpt_pkg::cfg_t    cfg_r, cfg_nxt;
  natpt_pkg::q_side_t q;
  logic               q_pop;
  logic               fifo_full;
  logic               clearing;
  logic               push_en;

  assign cfg_ready = 1'b1;

  // Writes to an index past the register list are accepted and ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        natpt_pkg::REG_EXT_IP:    cfg_nxt.ext_ip       = cfg_data;
        natpt_pkg::REG_PORT_BASE: cfg_nxt.port_base    = cfg_data[15:0];
        natpt_pkg::REG_TIMEOUT:   cfg_nxt.idle_timeout = cfg_data[15:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ext_ip       <= natpt_pkg::EXT_IP_RST;
      cfg_r.port_base    <= natpt_pkg::PORT_BASE_RST;
      cfg_r.idle_timeout <= natpt_pkg::TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // No request is taken while the pool bitmap is being cleared.
  assign in_full = fifo_full || clearing;
  assign push_en = in_push && !in_full;

  natpt_front u_front (
    .clk(clk), .rst_n(rst_n), .push_en(push_en), .item(in_item),
    .full(fifo_full), .q(q), .q_pop(q_pop)
  );

  natpt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .PORT_POOL(PORT_POOL)) u_back (
    .clk(clk), .rst_n(rst_n), .q(q), .q_pop(q_pop), .clearing(clearing),
    .cfg(cfg_r), .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );
endmodule
`default_nettype wire

/* src/natpt_checker.sv */
// Port-level checker for the NAT port translation table and its bind.
// Depends on natpt_pkg and nat_port_translation_table.
`default_nettype none
module natpt_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_empty,
  input wire logic                 out_pop,
  input wire natpt_pkg::out_item_t out_item
);
  // A waiting result is not withdrawn before it is popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("result changed while waiting");

  // Only ticks report removed entries.
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.verdict != natpt_pkg::V_TICK |->
      out_item.entries_removed == 9'd0)
    else $error("packet result reports removals");

  // Drops and ticks carry no translated tuple.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.verdict != natpt_pkg::V_FWD |->
      out_item.new_src_ip == 32'd0 && out_item.new_src_port == 16'd0 &&
      out_item.new_dst_ip == 32'd0 && out_item.new_dst_port == 16'd0)
    else $error("dropped request carries a tuple");

  // Verdict is one of the defined codes.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_item.verdict <= natpt_pkg::V_TICK)
    else $error("undefined verdict");
endmodule

bind nat_port_translation_table natpt_checker u_natpt_checker (
  .clk(clk), .rst_n(rst_n), .out_empty(out_empty), .out_pop(out_pop),
  .out_item(out_item)
);
`default_nettype wire
